// ===== hdl/csrmv_pkg.sv =====
// csrmv_pkg: shared constants, operation and status codes, and transfer types
// for the CSR sparse matrix-vector multiplier. No dependencies.

package csrmv_pkg;

  localparam int DEF_MAX_DIM = 1024;

  localparam int OP_W   = 2;
  localparam int POS_W  = 10;
  localparam int CNT_W  = 11;
  localparam int VAL_W  = 32;
  localparam int ACC_W  = 64;
  localparam int ST_W   = 2;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam int POS_SPAN = 2 ** POS_W;
  localparam int CNT_MAX  = 2 ** CNT_W - 1;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_LOAD      = 2'd0;
  localparam logic [OP_W-1:0] OP_NONZERO   = 2'd1;
  localparam logic [OP_W-1:0] OP_EMPTY_ROW = 2'd2;
  localparam logic [OP_W-1:0] OP_READ      = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_INDEX = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;

  localparam logic [CNT_W-1:0] ROWS_RESET = 11'd1024;
  localparam logic [CNT_W-1:0] COLS_RESET = 11'd1024;

  localparam logic [ACC_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic [CNT_W-1:0]        column;
    logic signed [VAL_W-1:0] data_value;
    logic                    row_last;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]        result_position;
    logic signed [ACC_W-1:0] result_value;
    logic [ST_W-1:0]         status;
  } out_item_t;

endpackage

// ===== hdl/csrmv_outq.sv =====
// csrmv_outq: small result queue between the arithmetic pipeline and the
// result channel. Depends on csrmv_pkg.

module csrmv_outq
  import csrmv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  out_item_t        push_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  output logic [OQ_CW-1:0] count
);

  out_item_t        q_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wptr_r, rptr_r;
  logic [OQ_CW-1:0] count_r, count_nxt;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_item  = q_r[rptr_r];
  assign count     = count_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + OQ_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - OQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : wptr_r + OQ_AW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : rptr_r + OQ_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/sparse_csr_matrix_vector_multiply.sv =====
// CSR sparse matrix-vector multiplier, A*x or A^T*x. Depends on csrmv_pkg and csrmv_outq.
// Throughput: one item per cycle, set by the column-sum read one stage ahead of its
// write-back with forwarding; in_ready drops while queue and pipeline hold four items.
// Each result passes through stage 1, stage 2 and the result queue before it is offered.
// Reset: synchronous; afterwards a clearing pass zeroes the column sums (MAX_DIM entries,
// at most 2047), one entry per cycle, while in_ready stays low.

module sparse_csr_matrix_vector_multiply
  import csrmv_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int VDEPTH = (MAX_DIM < POS_SPAN) ? MAX_DIM : POS_SPAN;
  localparam int VAW    = $clog2(VDEPTH);
  localparam int CLAMP  = (MAX_DIM < CNT_MAX) ? MAX_DIM : CNT_MAX;
  localparam int CAW    = $clog2(CLAMP);
  localparam int OCC_W  = OQ_CW + 1;
  localparam logic [CNT_W-1:0] CLAMP_V = CNT_W'(CLAMP);

  typedef struct packed {
    logic fwd;       // forward multiply-accumulate into the row sum
    logic colacc;    // transpose multiply-accumulate into a column sum
    logic rdok;      // read and clear within range
    logic bad;       // index error
    logic emit_row;  // forward row end
    logic emit_rd;   // column read
  } ctl_t;

  function automatic logic [CNT_W-1:0] eff(input logic [CNT_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (v > CLAMP_V) begin
      return CLAMP_V;
    end else begin
      return v;
    end
  endfunction

  // configuration
  logic             mode_r;
  logic [CNT_W-1:0] rows_r, cols_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MODE: mode_r <= pwdata[0];
        REG_ROWS: rows_r <= pwdata[CNT_W-1:0];
        REG_COLS: cols_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE: prdata = CFG_DW'(mode_r);
      REG_ROWS: prdata = CFG_DW'(rows_r);
      REG_COLS: prdata = CFG_DW'(cols_r);
      default:  prdata = '0;
    endcase
  end

  // stage 0: decode, vector store access, row counter
  logic             clear_busy_r;
  logic [CAW-1:0]   clear_addr_r;
  logic             s1_v_r, s2_v_r;
  logic [OQ_CW-1:0] oq_count;
  logic [OCC_W-1:0] occ;
  logic             acc;
  logic [CNT_W-1:0] eff_c, eff_r, colm1;
  logic             is_load, is_nz, is_empty, is_read;
  logic             col_ok, load_ok, read_ok, row_end;
  logic [CAW-1:0]   row_index_r, row_index_nxt;
  logic [CNT_W:0]   row_inc;
  logic [VAW-1:0]   vaddr;
  ctl_t             s0_ctl;

  logic signed [VAL_W-1:0] vmem [VDEPTH];
  logic signed [VAL_W-1:0] vec_rd_r;

  assign occ = OCC_W'(oq_count) + OCC_W'(s1_v_r) + OCC_W'(s2_v_r);
  assign in_ready = !clear_busy_r && (occ < OCC_W'(OQ_DEPTH));
  assign acc = in_valid && in_ready;

  assign eff_c    = eff(cols_r);
  assign eff_r    = eff(rows_r);
  assign colm1    = in_item.column - CNT_W'(1);
  assign is_load  = (in_item.operation == OP_LOAD);
  assign is_nz    = (in_item.operation == OP_NONZERO);
  assign is_empty = (in_item.operation == OP_EMPTY_ROW);
  assign is_read  = (in_item.operation == OP_READ);
  assign col_ok   = (in_item.column != '0) && (in_item.column <= eff_c);
  assign load_ok  = 32'(in_item.position) < 32'(MAX_DIM);
  assign read_ok  = CNT_W'(in_item.position) < eff_c;
  assign row_end  = (is_nz && in_item.row_last) || is_empty;

  assign row_inc       = (CNT_W+1)'(row_index_r) + (CNT_W+1)'(1);
  assign row_index_nxt = (row_inc >= (CNT_W+1)'(eff_r)) ? '0 : CAW'(row_inc);
  assign vaddr         = mode_r ? VAW'(row_index_r) : VAW'(colm1);

  always_comb begin
    s0_ctl.fwd      = is_nz && col_ok && !mode_r;
    s0_ctl.colacc   = is_nz && col_ok && mode_r;
    s0_ctl.rdok     = is_read && read_ok;
    s0_ctl.bad      = (is_load && !load_ok) || (is_nz && !col_ok) || (is_read && !read_ok);
    s0_ctl.emit_row = row_end && !mode_r;
    s0_ctl.emit_rd  = is_read;
  end

  always_ff @(posedge clk) begin
    if (acc && is_load && load_ok) begin
      vmem[VAW'(in_item.position)] <= in_item.data_value;
    end
    vec_rd_r <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_index_r <= '0;
    end else if (acc && row_end) begin
      row_index_r <= row_index_nxt;
    end
  end

  // stage 1: multiply, column-sum read
  ctl_t                    s1_ctl_r;
  logic [POS_W-1:0]        s1_pos_r;
  logic [CAW-1:0]          s1_caddr_r;
  logic signed [VAL_W-1:0] s1_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r   <= s0_ctl;
    s1_pos_r   <= is_read ? in_item.position : POS_W'(row_index_r);
    s1_caddr_r <= is_read ? CAW'(in_item.position) : CAW'(colm1);
    s1_val_r   <= in_item.data_value;
  end

  // stage 2: accumulate with saturation, write back, emit
  ctl_t                    s2_ctl_r;
  logic [POS_W-1:0]        s2_pos_r;
  logic [CAW-1:0]          s2_caddr_r;
  logic signed [ACC_W-1:0] s2_prod_r;

  logic [ACC_W-1:0] cmem [CLAMP];
  logic [ACC_W-1:0] cmem_rd_r;
  logic             wb_v_r;
  logic [CAW-1:0]   wb_addr_r;
  logic [ACC_W-1:0] wb_data_r;

  logic [ACC_W-1:0] row_sum_r, row_sum_nxt;
  logic [ST_W-1:0]  error_seen_r, error_seen_nxt, err_now;
  logic [ACC_W-1:0] col_cur, acc_a, sum, sat, row_val;
  logic             ovf, sat_hit, emit, cw_en;
  logic [ACC_W-1:0] cw_data;
  out_item_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_ctl_r   <= s1_ctl_r;
    s2_pos_r   <= s1_pos_r;
    s2_caddr_r <= s1_caddr_r;
    s2_prod_r  <= ACC_W'(vec_rd_r) * ACC_W'(s1_val_r);
  end

  always_comb begin
    col_cur = (wb_v_r && (wb_addr_r == s2_caddr_r)) ? wb_data_r : cmem_rd_r;
    acc_a   = s2_ctl_r.fwd ? row_sum_r : col_cur;
    sum     = acc_a + s2_prod_r;
    ovf     = (acc_a[ACC_W-1] == s2_prod_r[ACC_W-1]) && (sum[ACC_W-1] != acc_a[ACC_W-1]);
    sat     = ovf ? (acc_a[ACC_W-1] ? SAT_MIN : SAT_MAX) : sum;
    sat_hit = s2_v_r && (s2_ctl_r.fwd || s2_ctl_r.colacc) && ovf;
    emit    = s2_v_r && (s2_ctl_r.emit_row || s2_ctl_r.emit_rd);
    row_val = s2_ctl_r.fwd ? sat : row_sum_r;
    cw_en   = s2_v_r && (s2_ctl_r.colacc || s2_ctl_r.rdok);
    cw_data = s2_ctl_r.colacc ? sat : '0;

    if (sat_hit) begin
      err_now = ST_SAT;
    end else if (s2_v_r && s2_ctl_r.bad && (error_seen_r == ST_OK)) begin
      err_now = ST_INDEX;
    end else begin
      err_now = error_seen_r;
    end
    error_seen_nxt = emit ? ST_OK : err_now;

    row_sum_nxt = row_sum_r;
    if (s2_v_r && s2_ctl_r.emit_row) begin
      row_sum_nxt = '0;
    end else if (s2_v_r && s2_ctl_r.fwd) begin
      row_sum_nxt = sat;
    end

    res.result_position = s2_pos_r;
    res.status          = err_now;
    if (s2_ctl_r.emit_rd) begin
      res.result_value = s2_ctl_r.rdok ? col_cur : '0;
    end else begin
      res.result_value = row_val;
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy_r) begin
      cmem[clear_addr_r] <= '0;
    end else if (cw_en) begin
      cmem[s2_caddr_r] <= cw_data;
    end
    cmem_rd_r <= cmem[s1_caddr_r];
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= s2_caddr_r;
    wb_data_r <= cw_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clear_addr_r <= '0;
      wb_v_r       <= 1'b0;
      row_sum_r    <= '0;
      error_seen_r <= ST_OK;
    end else begin
      if (clear_busy_r) begin
        clear_addr_r <= clear_addr_r + CAW'(1);
        if (clear_addr_r == CAW'(CLAMP - 1)) begin
          clear_busy_r <= 1'b0;
        end
      end
      wb_v_r       <= cw_en;
      row_sum_r    <= row_sum_nxt;
      error_seen_r <= error_seen_nxt;
    end
  end

  csrmv_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_item (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .count     (oq_count)
  );

  a_no_work_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy_r |-> !(s1_v_r || s2_v_r || in_ready))
    else $error("item in flight during clearing pass");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (oq_count != OQ_CW'(OQ_DEPTH)))
    else $error("result pushed into a full queue");

  a_error_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (error_seen_r == ST_OK))
    else $error("status not cleared after a result");

  a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_v_r ##1 s2_v_r)
    else $error("accepted item lost in the pipeline");

endmodule

// ===== tb/sparse_csr_matrix_vector_multiply_tb.sv =====
// Self-checking testbench for the CSR sparse matrix-vector multiplier, forward and
// transpose modes, driven over valid/ready channels and the APB register port.
// Depends on csrmv_pkg and sparse_csr_matrix_vector_multiply.

module sparse_csr_matrix_vector_multiply_tb;
  import csrmv_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int IDLE_LIMIT   = 6000;
  localparam int HOLD_OFF     = 300;
  localparam int DRAIN_CYCLES = 4;

  class spmv_tracker;
    logic signed [VAL_W-1:0] vec_store [DEF_MAX_DIM];
    bit                      vec_written [DEF_MAX_DIM];
    logic [ACC_W-1:0]        col_sums [DEF_MAX_DIM];
    logic [ACC_W-1:0]        row_acc;
    int unsigned             row_idx;
    logic [ST_W-1:0]         sticky_status;
    bit                      transpose;
    logic [CNT_W-1:0]        rows_reg;
    logic [CNT_W-1:0]        cols_reg;
    out_item_t               pending_sums [$];
    int                      mismatches;
    int                      sums_checked;

    function new();
      foreach (col_sums[i]) begin
        col_sums[i]    = '0;
        vec_store[i]   = '0;
        vec_written[i] = 1'b0;
      end
      row_acc       = '0;
      row_idx       = 0;
      sticky_status = ST_OK;
      transpose     = 1'b0;
      rows_reg      = ROWS_RESET;
      cols_reg      = COLS_RESET;
      mismatches    = 0;
      sums_checked  = 0;
    endfunction

    function int unsigned clamp_count(logic [CNT_W-1:0] v);
      if (v == 0) return 1;
      if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
      return v;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_DW-1:0] v);
      case (idx)
        REG_MODE: transpose = v[0];
        REG_ROWS: rows_reg  = v[CNT_W-1:0];
        REG_COLS: cols_reg  = v[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void raise_status(logic [ST_W-1:0] code);
      if (code > sticky_status) sticky_status = code;
    endfunction

    function logic [ACC_W-1:0] sat_sum(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
      logic [ACC_W-1:0] s;
      s = a + b;
      if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
        raise_status(ST_SAT);
        return a[ACC_W-1] ? SAT_MIN : SAT_MAX;
      end
      return s;
    endfunction

    function logic [ACC_W-1:0] q_mul(logic signed [VAL_W-1:0] x, logic signed [VAL_W-1:0] y);
      longint p;
      p = longint'(x) * longint'(y);
      return p;
    endfunction

    function void queue_sum(int unsigned pos, logic [ACC_W-1:0] val);
      out_item_t e;
      e.result_position = POS_W'(pos);
      e.result_value    = val;
      e.status          = sticky_status;
      sticky_status     = ST_OK;
      pending_sums.push_back(e);
    endfunction

    function void next_row();
      row_idx = (row_idx + 1 >= clamp_count(rows_reg)) ? 0 : row_idx + 1;
    endfunction

    // true when a nonzero would multiply by a vector element not yet loaded
    function bit vec_missing(in_item_t it, output int unsigned idx);
      idx = 0;
      if (it.operation != OP_NONZERO || it.column == 0 || it.column > clamp_count(cols_reg))
        return 1'b0;
      idx = transpose ? row_idx : it.column - 1;
      return !vec_written[idx];
    endfunction

    function void absorb_item(in_item_t it);
      int unsigned      ncol;
      int unsigned      r;
      logic [ACC_W-1:0] s;
      ncol = clamp_count(cols_reg);
      case (it.operation)
        OP_LOAD: begin
          vec_store[it.position]   = it.data_value;
          vec_written[it.position] = 1'b1;
          return;
        end
        OP_READ: begin
          if (it.position >= ncol) begin
            raise_status(ST_INDEX);
            queue_sum(it.position, '0);
          end else begin
            queue_sum(it.position, col_sums[it.position]);
            col_sums[it.position] = '0;
          end
          return;
        end
        OP_NONZERO: begin
          if (it.column == 0 || it.column > ncol) begin
            raise_status(ST_INDEX);
          end else if (!transpose) begin
            row_acc = sat_sum(row_acc, q_mul(vec_store[it.column - 1], it.data_value));
          end else begin
            col_sums[it.column - 1] = sat_sum(col_sums[it.column - 1],
                                              q_mul(vec_store[row_idx], it.data_value));
          end
          if (!it.row_last) return;
        end
        default: ;
      endcase
      // row end
      if (!transpose) begin
        r       = row_idx;
        s       = row_acc;
        row_acc = '0;
        next_row();
        queue_sum(r, s);
      end else begin
        next_row();
      end
    endfunction

    function void compare_sum(out_item_t got);
      out_item_t want;
      sums_checked++;
      if (pending_sums.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: pos %0d value %h status %0d", $time,
                 got.result_position, got.result_value, got.status);
        return;
      end
      want = pending_sums.pop_front();
      if (got.result_position !== want.result_position) begin
        mismatches++;
        $display("%0t: result_position mismatch: expected %0d, actual %0d", $time,
                 want.result_position, got.result_position);
      end
      if (got.result_value !== want.result_value) begin
        mismatches++;
        $display("%0t: result_value mismatch: expected %h, actual %h", $time,
                 want.result_value, got.result_value);
      end
      if (got.status !== want.status) begin
        mismatches++;
        $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                 want.status, got.status);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_item;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  spmv_tracker csr_sums = new();

  int send_gap_pct;
  int recv_stall_pct;
  int hold_left;
  int items_sent;
  int settings_used;
  int transpose_settings;
  int idle_cycles;

  sparse_csr_matrix_vector_multiply u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t make_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                         logic [CNT_W-1:0] col, logic [VAL_W-1:0] val,
                                         logic last);
    in_item_t it;
    it.operation  = op;
    it.position   = pos;
    it.column     = col;
    it.data_value = val;
    it.row_last   = last;
    return it;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return '0;
      4, 5, 6: return $urandom;
      default: return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(9))
      0: return '0;
      1: return CNT_W'(CNT_MAX);
      2: return CNT_W'(DEF_MAX_DIM);
      3: return CNT_W'($urandom_range(CNT_MAX, 13));
      4: return CNT_W'(1);
      default: return CNT_W'($urandom_range(12, 2));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_column(int unsigned ncol, int unsigned span);
    case ($urandom_range(19))
      0: return CNT_W'($urandom_range(ncol, 1));
      1: return $urandom_range(1) ? '0 : CNT_W'($urandom_range(CNT_MAX, ncol + 1));
      default: return CNT_W'($urandom_range(span, 1));
    endcase
  endfunction

  function automatic in_item_t noise_item();
    return make_item(OP_W'($urandom_range(3)), POS_W'($urandom_range(POS_SPAN - 1)),
                     CNT_W'($urandom_range(CNT_MAX)), $urandom, 1'($urandom_range(1)));
  endfunction

  task automatic send_raw(input in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    csr_sums.absorb_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // loads the vector element a nonzero will use if it has never been written
  task automatic offer(input in_item_t it);
    int unsigned idx;
    if (csr_sums.vec_missing(it, idx))
      send_raw(make_item(OP_LOAD, POS_W'(idx), CNT_W'($urandom_range(CNT_MAX)), pick_value(),
                         1'($urandom_range(1))));
    send_raw(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (csr_sums.pending_sums.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    csr_sums.set_reg(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input bit mode, input logic [CNT_W-1:0] rows,
                               input logic [CNT_W-1:0] cols);
    settle();
    write_reg(REG_MODE, CFG_DW'(mode));
    write_reg(REG_ROWS, CFG_DW'(rows));
    write_reg(REG_COLS, CFG_DW'(cols));
    settings_used++;
    if (mode) transpose_settings++;
  endtask

  // well-formed matrix with random content, some noise, and in transpose mode or at random a readout
  task automatic random_phase();
    int unsigned ncol;
    int unsigned span;
    int unsigned nrows;
    int unsigned k;
    int          i;
    int          j;
    bit          mode;
    mode = 1'($urandom_range(1));
    apply_setting(mode, pick_count(), pick_count());
    ncol = csr_sums.clamp_count(csr_sums.cols_reg);
    span = (ncol < 12) ? ncol : 12;
    for (i = 0; i < span; i++)
      offer(make_item(OP_LOAD, POS_W'(i), CNT_W'($urandom_range(CNT_MAX)), pick_value(),
                      1'($urandom_range(1))));
    nrows = $urandom_range(8, 2);
    for (i = 0; i < nrows; i++) begin
      if ($urandom_range(9) == 0) offer(noise_item());
      k = $urandom_range(4);
      if (k == 0)
        offer(make_item(OP_EMPTY_ROW, POS_W'($urandom_range(POS_SPAN - 1)),
                        CNT_W'($urandom_range(CNT_MAX)), $urandom, 1'($urandom_range(1))));
      for (j = 0; j < k; j++)
        offer(make_item(OP_NONZERO, POS_W'($urandom_range(POS_SPAN - 1)),
                        pick_column(ncol, span), pick_value(), j == k - 1));
    end
    if (mode || $urandom_range(3) == 0) begin
      for (i = 0; i < span; i++)
        offer(make_item(OP_READ, POS_W'(i), CNT_W'($urandom_range(CNT_MAX)), $urandom,
                        1'($urandom_range(1))));
      offer(make_item(OP_READ, POS_W'($urandom_range(POS_SPAN - 1)),
                      CNT_W'($urandom_range(CNT_MAX)), $urandom, 1'($urandom_range(1))));
    end
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) csr_sums.compare_sum(out_item);
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int start_count;
    int i;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_item            = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    send_gap_pct       = 32;
    recv_stall_pct     = 60;
    hold_left          = 0;
    items_sent         = 0;
    settings_used      = 1;
    transpose_settings = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // forward mode at reset sizes: extremes, saturation both ways, bad columns
    offer(make_item(OP_LOAD, 10'd0, '0, 32'h7FFF_FFFF, 1'b0));
    offer(make_item(OP_LOAD, 10'd1023, CNT_W'(CNT_MAX), 32'h8000_0000, 1'b1));
    offer(make_item(OP_LOAD, 10'd1, '0, 32'h0001_0000, 1'b0));
    offer(make_item(OP_NONZERO, '0, 11'd1, 32'h7FFF_FFFF, 1'b0));
    offer(make_item(OP_NONZERO, '1, 11'd1024, 32'h8000_0000, 1'b1));
    for (i = 0; i < 3; i++)
      offer(make_item(OP_NONZERO, '0, 11'd1024, 32'h8000_0000, i == 2));
    for (i = 0; i < 3; i++)
      offer(make_item(OP_NONZERO, '0, 11'd1, 32'h8000_0000, i == 2));
    offer(make_item(OP_NONZERO, '0, 11'd0, 32'h1234_5678, 1'b1));
    offer(make_item(OP_NONZERO, '0, CNT_W'(CNT_MAX), 32'hFFFF_FFFF, 1'b0));
    offer(make_item(OP_EMPTY_ROW, '1, CNT_W'(CNT_MAX), '1, 1'b1));
    offer(make_item(OP_EMPTY_ROW, '0, '0, '0, 1'b0));
    offer(make_item(OP_NONZERO, '0, 11'd3, 32'hFFFF_0000, 1'b1));
    offer(make_item(OP_READ, 10'd5, '0, '0, 1'b0));
    offer(make_item(OP_READ, 10'd1023, '0, '0, 1'b0));

    // shrinking the row count below the current row
    apply_setting(1'b0, 11'd2, COLS_RESET);
    offer(make_item(OP_EMPTY_ROW, '0, '0, '0, 1'b0));
    offer(make_item(OP_EMPTY_ROW, '0, '0, '0, 1'b0));

    // transpose: accumulate, out-of-range column, reads in and out of range
    apply_setting(1'b1, 11'd2, 11'd3);
    offer(make_item(OP_NONZERO, '0, 11'd3, 32'h0002_0000, 1'b1));
    offer(make_item(OP_NONZERO, '0, 11'd4, 32'h0001_0000, 1'b0));
    offer(make_item(OP_EMPTY_ROW, '0, '0, '0, 1'b0));
    offer(make_item(OP_READ, 10'd2, '0, '0, 1'b0));
    offer(make_item(OP_READ, 10'd3, '0, '0, 1'b0));

    // receiver holds off while row sums keep coming, so the input stalls
    apply_setting(1'b0, ROWS_RESET, COLS_RESET);
    hold_left = HOLD_OFF;
    for (i = 0; i < 40; i++)
      offer($urandom_range(1) ? make_item(OP_EMPTY_ROW, '0, '0, $urandom, 1'b0)
                              : make_item(OP_NONZERO, '0, 11'd1, pick_value(), 1'b1));

    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      if (items_sent - start_count < RANDOM_ITEMS / 3) begin
        send_gap_pct   = 32;
        recv_stall_pct = 60;
      end else if (items_sent - start_count < 2 * RANDOM_ITEMS / 3) begin
        send_gap_pct   = 60;
        recv_stall_pct = 32;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      random_phase();
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d input transfers and %0d checked results over %0d register settings",
             items_sent, csr_sums.sums_checked, settings_used);
    $display("(%0d in transpose mode), including saturation, index errors and a long stall.",
             transpose_settings);
    if (csr_sums.mismatches == 0 && csr_sums.pending_sums.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/csrmv_pkg.sv
hdl/csrmv_outq.sv
hdl/sparse_csr_matrix_vector_multiply.sv
tb/sparse_csr_matrix_vector_multiply_tb.sv
